FILE: rtl/core/iilt_pkg.sv
package iilt_pkg;

  // Default table depth
  localparam int unsigned MAX_ENTRIES_DEF = 256;

  // Fixed word field widths
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned ID_W        = 8;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned COUNT_OUT_W = 9;

  // Wide enough for any address or count the depth range allows
  localparam int unsigned ADDR_EXT_W  = 17;

  // Operation codes; the spare code behaves as search
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

  // Link to a neighbour or to the head: id plus valid flag
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
  } link_t;

  // Per-entry data word
  typedef struct packed {
    logic               present;
    logic [VALUE_W-1:0] value;
  } data_word_t;

  // Memory strobes from the controller to the store
  typedef struct packed {
    logic rd_en;
    logic data_we;
    logic prev_we;
    logic next_we;
  } mem_ctl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_FIX,
    ST_WAIT
  } state_t;

endpackage

FILE: rtl/core/iilt_if.sv
// Command channel: one operation per word
interface iilt_cmd_if import iilt_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic [ID_W-1:0]           entry_id;
  logic signed [VALUE_W-1:0] new_value;

  modport source (output valid, output func, output entry_id, output new_value,
                  input ready);
  modport sink   (input valid, input func, input entry_id, input new_value,
                  output ready);
endinterface

// Result channel: one word per operation
interface iilt_res_if import iilt_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic signed [VALUE_W-1:0] stored_value;
  logic [ID_W-1:0]           prev_id;
  logic                      has_prev;
  logic [ID_W-1:0]           next_id;
  logic                      has_next;
  logic [ID_W-1:0]           head_id;
  logic                      list_nonempty;
  logic [COUNT_OUT_W-1:0]    entry_count;
  logic                      op_error;

  modport source (output valid, output found, output stored_value, output prev_id,
                  output has_prev, output next_id, output has_next, output head_id,
                  output list_nonempty, output entry_count, output op_error,
                  input ready);
  modport sink   (input valid, input found, input stored_value, input prev_id,
                  input has_prev, input next_id, input has_next, input head_id,
                  input list_nonempty, input entry_count, input op_error,
                  output ready);
endinterface

FILE: rtl/core/iilt_store.sv
// Entry store: data memory {present, value} and link memory {prev, next},
// one shared read address, registered read data, per-field link writes.
module iilt_store import iilt_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic         clk,
  input  mem_ctl_t     mem_ctl,
  input  logic [AW-1:0] rd_addr,
  input  logic [AW-1:0] data_addr,
  input  logic [AW-1:0] link_addr,
  input  data_word_t   data_wdata,
  input  link_t        prev_wdata,
  input  link_t        next_wdata,
  output data_word_t   data_rdata,
  output link_t        prev_rdata,
  output link_t        next_rdata
);

  data_word_t data_mem [MAX_ENTRIES];
  link_t      prev_mem [MAX_ENTRIES];
  link_t      next_mem [MAX_ENTRIES];

  // Data memory
  always_ff @(posedge clk) begin
    if (mem_ctl.data_we) begin
      data_mem[data_addr] <= data_wdata;
    end
    if (mem_ctl.rd_en) begin
      data_rdata <= data_mem[rd_addr];
    end
  end

  // Link memory, prev and next halves written separately (lane enables)
  always_ff @(posedge clk) begin
    if (mem_ctl.prev_we) begin
      prev_mem[link_addr] <= prev_wdata;
    end
    if (mem_ctl.next_we) begin
      next_mem[link_addr] <= next_wdata;
    end
    if (mem_ctl.rd_en) begin
      prev_rdata <= prev_mem[rd_addr];
      next_rdata <= next_mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/iilt_ctrl.sv
// Sequencer: clearing pass, read / modify / fix-up per operation,
// head and count registers, result register.
module iilt_ctrl import iilt_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  iilt_cmd_if.sink      cmd,
  iilt_res_if.source    res,
  output mem_ctl_t      mem_ctl,
  output logic [AW-1:0] rd_addr,
  output logic [AW-1:0] data_addr,
  output logic [AW-1:0] link_addr,
  output data_word_t    data_wdata,
  output link_t         prev_wdata,
  output link_t         next_wdata,
  input  data_word_t    data_rdata,
  input  link_t         prev_rdata,
  input  link_t         next_rdata
);

  function automatic logic [AW-1:0] id_to_addr(input logic [ID_W-1:0] id);
    logic [ADDR_EXT_W-1:0] ext;
    ext = {{(ADDR_EXT_W-ID_W){1'b0}}, id};
    return ext[AW-1:0];
  endfunction

  function automatic logic id_in_range(input logic [ID_W-1:0] id);
    logic [ADDR_EXT_W-1:0] ext;
    ext = {{(ADDR_EXT_W-ID_W){1'b0}}, id};
    return ext < ADDR_EXT_W'(MAX_ENTRIES);
  endfunction

  state_t state, state_next;

  logic [AW-1:0]      clr_addr;
  logic [FUNC_W-1:0]  op_func;
  logic [ID_W-1:0]    op_id;
  logic [VALUE_W-1:0] op_value;
  logic               op_in_range;
  link_t              head;
  logic [CW-1:0]      count;

  // Pending fix-up of a neighbour's prev link
  logic               fix_en;
  logic [AW-1:0]      fix_addr;
  link_t              fix_link;

  // Entry part of the result, settled in the lookup cycle
  logic               rs_found;
  logic [VALUE_W-1:0] rs_value;
  link_t              rs_prev;
  link_t              rs_next;
  logic               rs_err;

  logic               out_free;
  logic               out_load;
  logic               present;
  logic               ins_ok;
  logic               rem_ok;
  logic [ADDR_EXT_W-1:0] cnt_ext;

  assign out_free = !res.valid || res.ready;
  assign out_load = ((state == ST_FIX) || (state == ST_WAIT)) && out_free;
  assign present  = op_in_range && data_rdata.present;
  assign ins_ok   = (op_func == FUNC_INSERT) && op_in_range && !data_rdata.present;
  assign rem_ok   = (op_func == FUNC_REMOVE) && present;
  assign cnt_ext  = ADDR_EXT_W'(count);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(MAX_ENTRIES - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd.valid) state_next = ST_LOOK;
      end
      ST_LOOK: state_next = ST_FIX;
      ST_FIX, ST_WAIT: begin
        state_next = out_free ? ST_IDLE : ST_WAIT;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory strobes and command ready
  always_comb begin
    cmd.ready  = (state == ST_IDLE);
    mem_ctl    = '0;
    rd_addr    = id_to_addr(cmd.entry_id);
    data_addr  = id_to_addr(op_id);
    link_addr  = id_to_addr(op_id);
    data_wdata = '0;
    prev_wdata = '0;
    next_wdata = '0;
    case (state)
      ST_CLEAR: begin
        mem_ctl.data_we = 1'b1;
        data_addr       = clr_addr;
      end
      ST_IDLE: begin
        mem_ctl.rd_en = cmd.valid;
      end
      ST_LOOK: begin
        if (ins_ok) begin
          // new entry at the head: no prev, next is the old head
          mem_ctl.data_we  = 1'b1;
          data_wdata       = {1'b1, op_value};
          mem_ctl.prev_we  = 1'b1;
          mem_ctl.next_we  = 1'b1;
          next_wdata       = head;
        end else if (rem_ok) begin
          mem_ctl.data_we = 1'b1;
          if (prev_rdata.valid) begin
            mem_ctl.next_we = 1'b1;
            link_addr       = id_to_addr(prev_rdata.id);
            next_wdata      = next_rdata;
          end
        end
      end
      ST_FIX: begin
        mem_ctl.prev_we = fix_en;
        link_addr       = fix_addr;
        prev_wdata      = fix_link;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      head      <= '0;
      count     <= '0;
      fix_en    <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (state == ST_LOOK) begin
        fix_en <= 1'b0;
        if (ins_ok) begin
          head   <= '{valid: 1'b1, id: op_id};
          count  <= count + CW'(1);
          fix_en <= head.valid;
        end else if (rem_ok) begin
          if (!prev_rdata.valid) head <= next_rdata;
          count  <= count - CW'(1);
          fix_en <= next_rdata.valid;
        end
      end
      if (out_load) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // Operation capture, lookup result and fix-up target
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      op_func     <= cmd.func;
      op_id       <= cmd.entry_id;
      op_value    <= cmd.new_value;
      op_in_range <= id_in_range(cmd.entry_id);
    end
    if (state == ST_LOOK) begin
      fix_addr <= ins_ok ? id_to_addr(head.id) : id_to_addr(next_rdata.id);
      fix_link <= ins_ok ? link_t'{valid: 1'b1, id: op_id} : prev_rdata;
      rs_found <= present;
      rs_value <= present ? data_rdata.value : '0;
      rs_prev  <= present ? prev_rdata : '0;
      rs_next  <= present ? next_rdata : '0;
      rs_err   <= 1'b0;
      case (op_func)
        FUNC_INSERT: begin
          if (ins_ok) begin
            rs_found <= 1'b1;
            rs_value <= op_value;
            rs_prev  <= '0;
            rs_next  <= head;
          end else begin
            rs_err <= 1'b1;
          end
        end
        FUNC_REMOVE: begin
          rs_found <= 1'b0;
          rs_value <= '0;
          rs_prev  <= '0;
          rs_next  <= '0;
          rs_err   <= !present;
        end
        default: ;
      endcase
    end
    // Result register, head and count already updated
    if (out_load) begin
      res.found         <= rs_found;
      res.stored_value  <= rs_value;
      res.has_prev      <= rs_prev.valid;
      res.prev_id       <= rs_prev.valid ? rs_prev.id : '0;
      res.has_next      <= rs_next.valid;
      res.next_id       <= rs_next.valid ? rs_next.id : '0;
      res.list_nonempty <= head.valid;
      res.head_id       <= head.valid ? head.id : '0;
      res.entry_count   <= cnt_ext[COUNT_OUT_W-1:0];
      res.op_error      <= rs_err;
    end
  end

endmodule

FILE: rtl/core/id_indexed_linked_list_table.sv
// Table of entries indexed by id, chained in a doubly linked list.
// cmd channel: one word per operation (func: insert at head, remove,
// search; entry_id; new_value used by insert). res channel: one word per
// command with the entry's value and neighbours, the list head, the entry
// count and an error flag (insert of a present or out-of-range id, remove
// of an absent id). Ids at or above MAX_ENTRIES are never present.
// Sequence: each command is accepted in idle with the memory read, then a
// lookup cycle writes the entry and one neighbour link, and a fix-up cycle
// writes the other neighbour's prev link and loads the result register;
// the next command is accepted only back in idle. The fix-up step is needed
// because the link memory has a single write address.
// Reset: a clearing pass writes every entry absent with cmd.ready low;
// head and count start empty.
// Stall: a result waits in the output register; the next command is still
// accepted and processed up to its result, which is held until res.ready.
module id_indexed_linked_list_table import iilt_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic       clk,
  input  logic       rst,
  iilt_cmd_if.sink   cmd,
  iilt_res_if.source res
);

  mem_ctl_t      mem_ctl;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] data_addr;
  logic [AW-1:0] link_addr;
  data_word_t    data_wdata;
  data_word_t    data_rdata;
  link_t         prev_wdata;
  link_t         next_wdata;
  link_t         prev_rdata;
  link_t         next_rdata;

  iilt_ctrl #(.MAX_ENTRIES(MAX_ENTRIES)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .res        (res),
    .mem_ctl    (mem_ctl),
    .rd_addr    (rd_addr),
    .data_addr  (data_addr),
    .link_addr  (link_addr),
    .data_wdata (data_wdata),
    .prev_wdata (prev_wdata),
    .next_wdata (next_wdata),
    .data_rdata (data_rdata),
    .prev_rdata (prev_rdata),
    .next_rdata (next_rdata)
  );

  iilt_store #(.MAX_ENTRIES(MAX_ENTRIES)) u_store (
    .clk        (clk),
    .mem_ctl    (mem_ctl),
    .rd_addr    (rd_addr),
    .data_addr  (data_addr),
    .link_addr  (link_addr),
    .data_wdata (data_wdata),
    .prev_wdata (prev_wdata),
    .next_wdata (next_wdata),
    .data_rdata (data_rdata),
    .prev_rdata (prev_rdata),
    .next_rdata (next_rdata)
  );

endmodule

FILE: rtl/core/iilt_checker.sv
// Port-level checks on the table
module iilt_checker import iilt_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      cmd_ready,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic                      found,
  input logic signed [VALUE_W-1:0] stored_value,
  input logic                      has_prev,
  input logic                      has_next,
  input logic [ID_W-1:0]           head_id,
  input logic                      list_nonempty,
  input logic [COUNT_OUT_W-1:0]    entry_count
);

  // Reset starts the clearing pass: nothing taken, nothing shown
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res_valid && !cmd_ready)
    else $error("command taken or result shown right after reset");

  // An empty list and a zero count go together
  a_count_head: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((entry_count == '0) == !list_nonempty))
    else $error("entry count disagrees with head validity");

  // An absent entry reports no value and no neighbours
  a_absent_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !found) |-> (stored_value == '0) && !has_prev && !has_next)
    else $error("absent entry reports value or neighbours");

  // A stalled result word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid && $stable(stored_value)
      && $stable(head_id) && $stable(entry_count) && $stable(found))
    else $error("stalled result word changed");

endmodule

bind id_indexed_linked_list_table iilt_checker u_iilt_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_ready     (cmd.ready),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .found         (res.found),
  .stored_value  (res.stored_value),
  .has_prev      (res.has_prev),
  .has_next      (res.has_next),
  .head_id       (res.head_id),
  .list_nonempty (res.list_nonempty),
  .entry_count   (res.entry_count)
);
